@@ src/fpexp_pkg.sv @@
// ----------------------------------------------------------------------------
// fpexp_pkg: shared types and tables of the fixed-point exponential
// Holds the e^n tables, the Taylor coefficients and the result-kind codes.
// ----------------------------------------------------------------------------
package fpexp_pkg;

	// pipeline geometry
	localparam int unsigned TermCount = 8;
	localparam int unsigned DivSteps  = 30;

	// fixed-point constants
	localparam logic [30:0] SatMax   = 31'h7FFF_FFFF;
	localparam logic [30:0] OneQ15   = 31'h0000_8000;
	localparam logic [3:0]  IpLimit  = 4'd12;

	// how the final result is formed
	typedef enum logic [1:0] {
		KIND_NORM = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_SAT  = 2'd2,
		KIND_ZERO = 2'd3
	} kind_t;

	// sideband that travels with each transaction
	typedef struct packed {
		logic       neg;
		kind_t      kind;
		logic [3:0] ip;
	} side_t;

	// integer part of e^n
	function automatic logic [15:0] whole_part(input logic [3:0] n);
		logic [15:0] r;
		case (n)
			4'd0:    r = 16'h0001;
			4'd1:    r = 16'h0002;
			4'd2:    r = 16'h0007;
			4'd3:    r = 16'h0014;
			4'd4:    r = 16'h0036;
			4'd5:    r = 16'h0094;
			4'd6:    r = 16'h0193;
			4'd7:    r = 16'h0448;
			4'd8:    r = 16'h0BA4;
			4'd9:    r = 16'h1FA7;
			4'd10:   r = 16'h560A;
			4'd11:   r = 16'hE9E2;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	// Q15 fraction of e^n
	function automatic logic [15:0] frac_part(input logic [3:0] n);
		logic [15:0] r;
		case (n)
			4'd0:    r = 16'h0000;
			4'd1:    r = 16'h5BF1;
			4'd2:    r = 16'h31CD;
			4'd3:    r = 16'h0AF3;
			4'd4:    r = 16'h4C90;
			4'd5:    r = 16'h34E2;
			4'd6:    r = 16'h36E3;
			4'd7:    r = 16'h510B;
			4'd8:    r = 16'h7A9F;
			4'd9:    r = 16'h0ABE;
			4'd10:   r = 16'h3B9F;
			4'd11:   r = 16'h1224;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	// Taylor coefficients 1/(k+1)! in Q15
	function automatic logic [15:0] series_coef(input logic [2:0] k);
		logic [15:0] r;
		case (k)
			3'd0:    r = 16'h7FFF;
			3'd1:    r = 16'h4000;
			3'd2:    r = 16'h1555;
			3'd3:    r = 16'h0555;
			3'd4:    r = 16'h0111;
			3'd5:    r = 16'h002E;
			3'd6:    r = 16'h0007;
			3'd7:    r = 16'h0001;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

@@ src/fixed_point_exponential.sv @@
// ----------------------------------------------------------------------------
// fixed_point_exponential: pipelined e^x in Q17.15
// Range reduction, eight-term Taylor series, e^n table product and a
// one-bit-per-stage divider for negative arguments.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------
//  input   | x_valid / x_ready    | x_value (signed Q17.15)
//  result  | res_valid / res_ready| exp_value, saturated
//
// One transaction enters per cycle while the result is not stalled; stages: decode, eight
// series stages, three product stages, thirty divider stages, output.
// The divider depth (one quotient bit per stage) sets the latency.
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fixed_point_exponential (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               x_valid,
	output logic               x_ready,
	input  logic signed [31:0] x_value,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [30:0]        exp_value,
	output logic               saturated
);
	import fpexp_pkg::*;

	// global advance
	logic adv;
	assign adv     = !res_valid || res_ready;
	assign x_ready = adv;

	// decode: sign, magnitude, integer part and centered fraction
	logic [31:0]        dec_mag;
	logic [17:0]        dec_ipw;
	logic signed [15:0] dec_fr;
	side_t              dec_side;

	always_comb begin
		dec_mag       = x_value[31] ? (32'd0 - $unsigned(x_value)) : $unsigned(x_value);
		dec_ipw       = {1'b0, dec_mag[31:15]} + {17'd0, dec_mag[14]};
		dec_fr        = signed'({dec_mag[14], dec_mag[14:0]});
		dec_side.neg  = x_value[31];
		dec_side.ip   = dec_ipw[3:0];
		if (x_value == 32'sd0) begin
			dec_side.kind = KIND_ONE;
		end else if (dec_ipw >= {14'd0, IpLimit}) begin
			dec_side.kind = KIND_SAT;
		end else begin
			dec_side.kind = KIND_NORM;
		end
	end

	// series pipeline, index 0 is the decode stage
	logic               tay_v_s    [0:TermCount];
	side_t              tay_side_s [0:TermCount];
	logic signed [15:0] tay_fr_s   [0:TermCount];
	logic signed [16:0] tay_z_s    [0:TermCount];
	logic signed [33:0] tay_acc_s  [0:TermCount];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tay_v_s[0] <= 1'b0;
		end else if (adv) begin
			tay_v_s[0] <= x_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tay_side_s[0] <= dec_side;
			tay_fr_s[0]   <= dec_fr;
			tay_z_s[0]    <= {dec_fr[15], dec_fr};
			tay_acc_s[0]  <= '0;
		end
	end

	// one series term per stage: accumulate z*c, next power rounded
	for (genvar k = 0; k < TermCount; k++) begin : g_term
		logic signed [32:0] zf;
		logic signed [32:0] zr;
		logic signed [33:0] zc;

		always_comb begin
			zf = tay_z_s[k] * tay_fr_s[k];
			zr = (zf + 33'sh4000) >>> 15;
			zc = tay_z_s[k] * signed'({1'b0, series_coef(3'(k))});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tay_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				tay_v_s[k+1] <= tay_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tay_side_s[k+1] <= tay_side_s[k];
				tay_fr_s[k+1]   <= tay_fr_s[k];
				tay_z_s[k+1]    <= zr[16:0];
				tay_acc_s[k+1]  <= tay_acc_s[k] + zc;
			end
		end
	end

	// round the series sum into e^f in Q15
	logic signed [33:0] acc_rnd;
	logic [15:0]        t_val;
	assign acc_rnd = (tay_acc_s[TermCount] + 34'sh4000) >>> 15;
	assign t_val   = acc_rnd[15:0] + 16'h7FFF;

	logic        v_s10;
	side_t       side_s10;
	logic [15:0] t_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= tay_v_s[TermCount];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s10 <= tay_side_s[TermCount];
			t_s10    <= t_val;
		end
	end

	// products with the e^n table entries
	logic        v_s11;
	side_t       side_s11;
	logic [31:0] pf_s11;
	logic [31:0] pw_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s11 <= side_s10;
			pf_s11   <= t_s10 * frac_part(side_s10.ip);
			pw_s11   <= t_s10 * whole_part(side_s10.ip);
		end
	end

	// combine products, detect overflow and a zero result of a negative argument
	logic [32:0] prod;
	logic        prod_ovf;
	side_t       side_prod;

	always_comb begin
		prod      = (({1'b0, pf_s11} + 33'h4000) >> 15) + {1'b0, pw_s11};
		prod_ovf  = prod > {2'b00, SatMax};
		side_prod = side_s11;
		if (side_s11.kind == KIND_NORM) begin
			if (prod_ovf) begin
				side_prod.kind = KIND_SAT;
			end else if (side_s11.neg && prod == 33'd0) begin
				side_prod.kind = KIND_ZERO;
			end
		end
	end

	// divider pipeline, index 0 is the product stage
	logic        div_v_s    [0:DivSteps];
	side_t       div_side_s [0:DivSteps];
	logic [30:0] div_d_s    [0:DivSteps];
	logic [30:0] div_rem_s  [0:DivSteps];
	logic [29:0] div_q_s    [0:DivSteps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (adv) begin
			div_v_s[0] <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_side_s[0] <= side_prod;
			div_d_s[0]    <= prod[30:0];
			div_rem_s[0]  <= '0;
			div_q_s[0]    <= '0;
		end
	end

	// restoring division of the all-ones dividend, one quotient bit per stage
	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		logic [31:0] sh;
		logic        ge;

		always_comb begin
			sh = {div_rem_s[j], 1'b1};
			ge = sh >= {1'b0, div_d_s[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				div_v_s[j+1] <= div_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_side_s[j+1] <= div_side_s[j];
				div_d_s[j+1]    <= div_d_s[j];
				div_rem_s[j+1]  <= ge ? 31'(sh - {1'b0, div_d_s[j]}) : sh[30:0];
				div_q_s[j+1]    <= {div_q_s[j][28:0], ge};
			end
		end
	end

	// final result select
	side_t       fin_side;
	logic [30:0] fin_val;
	logic        fin_sat;

	always_comb begin
		fin_side = div_side_s[DivSteps];
		case (fin_side.kind)
			KIND_ONE: begin
				fin_val = OneQ15;
				fin_sat = 1'b0;
			end
			KIND_SAT: begin
				fin_val = fin_side.neg ? 31'd0 : SatMax;
				fin_sat = 1'b1;
			end
			KIND_ZERO: begin
				fin_val = 31'd0;
				fin_sat = 1'b0;
			end
			KIND_NORM: begin
				fin_val = fin_side.neg ? {1'b0, div_q_s[DivSteps]} : div_d_s[DivSteps];
				fin_sat = 1'b0;
			end
			default: begin
				fin_val = 31'd0;
				fin_sat = 1'b0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= div_v_s[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			exp_value <= fin_val;
			saturated <= fin_sat;
		end
	end

	// a saturated result is either zero or the maximum
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && saturated) |-> (exp_value == 31'd0 || exp_value == SatMax))
		else $error("saturated result with intermediate value");

	// a stalled result freezes the divider tail
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> ($stable(div_q_s[DivSteps]) &&
			$stable(div_v_s[DivSteps])))
		else $error("pipeline moved while result stalled");

	// input is taken exactly when the pipeline advances
	a_ready_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(x_valid && x_ready) |=> tay_v_s[0])
		else $error("accepted transaction not captured");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the fixed-point exponential
// Streams directed and random Q17.15 arguments through the pipeline with
// random idling on both channels and checks every result against an
// in-bench predictor of e^x, in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               x_valid;
	logic               x_ready;
	logic signed [31:0] x_value;
	logic               res_valid;
	logic               res_ready;
	logic [30:0]        exp_value;
	logic               saturated;

	typedef struct packed {
		logic [30:0] value;
		logic        sat;
	} exp_res_t;

	logic signed [31:0] arg_queue[$];
	exp_res_t           exp_queue[$];
	int                 err_count;
	bit                 hold_off;
	bit                 calm;
	int                 tx_idle;
	int                 rx_idle;

	fixed_point_exponential dut (
		.clk(clk), .arst_n(arst_n),
		.x_valid(x_valid), .x_ready(x_ready), .x_value(x_value),
		.res_valid(res_valid), .res_ready(res_ready),
		.exp_value(exp_value), .saturated(saturated)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// floor division by 2^15 of a signed value
	function automatic longint floor15(input longint v);
		return v >>> 15;
	endfunction

	// predicted e^x for one argument
	function automatic exp_res_t exp_of(input logic [31:0] x);
		longint   w_tab[12] = '{1, 2, 7, 20, 54, 148, 403, 1096, 2980, 8103, 22026, 59874};
		longint   f_tab[12] = '{0, 23537, 12749, 2803, 19600, 13538, 14051, 20747,
			31391, 2750, 15263, 4644};
		longint   c_tab[8] = '{32767, 16384, 5461, 1365, 273, 46, 7, 1};
		exp_res_t r;
		bit       neg;
		logic [31:0] mag;
		longint   ip, fr, z, acc, t, prod;
		if (x == 32'h0) begin
			r.value = 31'h8000; r.sat = 1'b0; return r;
		end
		if (x == 32'h8000_0000) begin
			r.value = '0; r.sat = 1'b1; return r;
		end
		neg = x[31];
		mag = neg ? -x : x;
		ip = mag >> 15;
		fr = mag & 32'h7FFF;
		if (fr & 32'h4000) begin
			fr -= 32'h8000; ip++;
		end
		r.sat = 1'b1;
		r.value = neg ? 31'h0 : 31'h7FFF_FFFF;
		if (ip >= 12) return r;
		acc = 0;
		z = fr;
		for (int k = 0; k < 8; k++) begin
			acc += z * c_tab[k];
			z = floor15(z * fr + 16384);
		end
		t = (floor15(acc + 16384) + 32767) & 16'hFFFF;
		prod = ((t * f_tab[ip] + 16384) >> 15) + t * w_tab[ip];
		if (prod > 64'h7FFF_FFFF) return r;
		r.sat = 1'b0;
		if (!neg) r.value = prod[30:0];
		else if (prod == 0) r.value = '0;
		else r.value = 31'((64'h7FFF_FFFF / prod) >> 1);
		return r;
	endfunction

	// driver: present pending arguments, idle in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_valid <= 1'b0;
			x_value <= '0;
			tx_idle <= 0;
		end else begin
			if (x_valid && x_ready) exp_queue.push_back(exp_of(x_value));
			if (!x_valid || x_ready) begin
				if (tx_idle > 0) begin
					tx_idle <= tx_idle - 1;
					x_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					tx_idle <= $urandom_range(1, 13);
					x_valid <= 1'b0;
				end else if (arg_queue.size() > 0 && !hold_off) begin
					x_value <= arg_queue.pop_front();
					x_valid <= 1'b1;
				end else begin
					x_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: stall in bursts, compare each result transaction
	always @(posedge clk or negedge arst_n) begin
		exp_res_t e;
		if (!arst_n) begin
			res_ready <= 1'b0;
			rx_idle <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (exp_queue.size() == 0) begin
					$display("%0t: unexpected result exp_value=%h saturated=%b",
						$time, exp_value, saturated);
					err_count++;
				end else begin
					e = exp_queue.pop_front();
					if (exp_value !== e.value) begin
						$display("%0t: exp_value expected %h actual %h",
							$time, e.value, exp_value);
						err_count++;
					end
					if (saturated !== e.sat) begin
						$display("%0t: saturated expected %b actual %b",
							$time, e.sat, saturated);
						err_count++;
					end
				end
			end
			if (rx_idle > 0) begin
				rx_idle <= rx_idle - 1;
				res_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				rx_idle <= $urandom_range(1, 13);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// random argument, biased toward the interesting range
	function automatic logic [31:0] rand_arg();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom();
			1: v = $urandom_range(0, 32'h6_0000);
			2: v = -$urandom_range(0, 32'h6_0000);
			3: v = 32'(($urandom_range(0, 11) << 15) + 32'h3FFF + $urandom_range(0, 2));
			default: v = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 32'h3_0000);
		endcase
		return v;
	endfunction

	// stimulus
	initial begin
		hold_off = 0;
		calm = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero, extremes, table edges, half-fraction rounding
		arg_queue.push_back(32'h0);
		arg_queue.push_back(32'h8000_0000);
		arg_queue.push_back(32'h7FFF_FFFF);
		arg_queue.push_back(32'h8000_0001);
		arg_queue.push_back(32'h1);
		arg_queue.push_back(32'hFFFF_FFFF);
		arg_queue.push_back(32'h8000);
		arg_queue.push_back(-32'sh8000);
		arg_queue.push_back(32'h4000);
		arg_queue.push_back(32'h3FFF);
		arg_queue.push_back(-32'sh4000);
		arg_queue.push_back(32'h5_C000);
		arg_queue.push_back(32'h5_BFFF);
		arg_queue.push_back(32'h5_8000);
		arg_queue.push_back(32'h5_4000);
		arg_queue.push_back(-32'sh5_8000);
		arg_queue.push_back(32'h5_FFFF);
		arg_queue.push_back(-32'sh5_FFFF);
		arg_queue.push_back(-32'sh5_4000);
		arg_queue.push_back(-32'sh6_0000);
		arg_queue.push_back(32'h55_5555);
		arg_queue.push_back(32'hAAAA_AAAA);

		// pause until the pipeline has drained
		wait (arg_queue.size() == 0);
		hold_off = 1;
		@(posedge clk);
		wait (exp_queue.size() == 0 && !x_valid);
		repeat (60) @(posedge clk);
		hold_off = 0;

		for (int i = 0; i < 1300; i++) arg_queue.push_back(rand_arg());
		wait (arg_queue.size() == 0);
		calm = 1;
		for (int i = 0; i < 250; i++) arg_queue.push_back(rand_arg());
		wait (arg_queue.size() == 0);
		@(posedge clk);
		wait (!x_valid);
		wait (exp_queue.size() == 0);
		repeat (60) @(posedge clk);
		if (err_count == 0 && exp_queue.size() == 0) begin
			$display("PASS fixed_point_exponential");
		end else begin
			$display("FAIL fixed_point_exponential");
		end
		$finish;
	end

	// timeout
	initial begin
		#2ms;
		$display("FAIL fixed_point_exponential");
		$finish;
	end

endmodule

@@ filelist.f @@
src/fpexp_pkg.sv
src/fixed_point_exponential.sv
dv/tb_top.sv
